@@ sv/fat_chain_allocator_assert.svh @@
// Assertion macros for the block chain allocator.
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define FCA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fca assertion failed");
`define FCA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("fca assertion failed");
`else
`define FCA_ASSERT(lbl, clk, rst, prop)
`define FCA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/fca_pkg.sv @@
`default_nettype none
package fca_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int ADDR_W     = $clog2(NUM_BLOCKS);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int KIND_W     = 3;
  localparam int STAT_W     = 2;

  localparam logic [IDX_W-1:0] CFG_RESET = IDX_W'(3);

  // reserved blocks after format: 0..3 used, 1 -> 2
  localparam int RSV_LAST     = 3;
  localparam int RSV_LINK_SRC = 1;
  localparam int RSV_LINK_DST = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FORMAT = 3'd0,
    KIND_ALLOC  = 3'd1,
    KIND_EXTEND = 3'd2,
    KIND_FREE   = 3'd3,
    KIND_FIND   = 3'd4,
    KIND_NEXT   = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_OVERRUN = 2'd2
  } status_t;

  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] nxt;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } tbl_wr_t;

endpackage
`default_nettype wire

@@ sv/fca_if.sv @@
`default_nettype none
interface fca_cmd_if import fca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  block_index;
  modport source (output valid, kind, block_index, input ready);
  modport sink   (input valid, kind, block_index, output ready);
endinterface

interface fca_rsp_if import fca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  result_index;
  logic [CNT_W-1:0]  block_count;
  modport source (output valid, status, result_index, block_count, input ready);
  modport sink   (input valid, status, result_index, block_count, output ready);
endinterface

interface fca_cfg_if import fca_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] first_search_index;
  modport source (output valid, first_search_index, input ready);
  modport sink   (input valid, first_search_index, output ready);
endinterface
`default_nettype wire

@@ sv/fca_table.sv @@
`default_nettype none
module fca_table import fca_pkg::*; (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/fca_ctrl.sv @@
`default_nettype none
`include "fat_chain_allocator_assert.svh"
module fca_ctrl import fca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fca_cmd_if.sink           cmd,
  fca_rsp_if.source         rsp,
  input  logic [IDX_W-1:0]  search_start,
  output tbl_wr_t           wr,
  output logic [ADDR_W-1:0] raddr,
  input  entry_t            rdata
);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_FMT      = 12'b000000000100,
    S_SRCH_RD  = 12'b000000001000,
    S_SRCH_CHK = 12'b000000010000,
    S_LINK     = 12'b000000100000,
    S_CLAIM    = 12'b000001000000,
    S_WALK_RD  = 12'b000010000000,
    S_WALK_CHK = 12'b000100000000,
    S_NEXT_RD  = 12'b001000000000,
    S_NEXT_CHK = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t            state, state_next;
  logic [PTR_W-1:0]  ptr, ptr_next, ptr_inc;
  logic [ADDR_W-1:0] cur, cur_next;
  logic [KIND_W-1:0] kind_r, kind_r_next;
  logic [CNT_W-1:0]  count, count_next, count_inc;
  logic [STAT_W-1:0] status_r, status_r_next;
  logic [IDX_W-1:0]  result_r, result_r_next;
  logic              out_valid, out_valid_next;
  logic              out_load;
  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_result;
  logic [CNT_W-1:0]  out_count;
  logic [IDX_W-1:0]  start;
  logic              in_table;
  logic              sweep_end;

  // shared step unit
  assign ptr_inc   = ptr + 1'b1;
  assign count_inc = count + 1'b1;
  assign sweep_end = (32'(ptr_inc) == NUM_BLOCKS);
  assign start     = (search_start == '0) ? IDX_W'(1) : search_start;
  assign in_table  = (32'(cmd.block_index) < NUM_BLOCKS);

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_index = out_result;
  assign rsp.block_count  = out_count;

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    cur_next       = cur;
    kind_r_next    = kind_r;
    count_next     = count;
    status_r_next  = status_r;
    result_r_next  = result_r;
    out_valid_next = out_valid && !rsp.ready;
    out_load       = 1'b0;
    wr             = '0;
    raddr          = ptr[ADDR_W-1:0];
    unique case (state)
      S_CLEAR: begin
        wr.en    = 1'b1;
        wr.addr  = ptr[ADDR_W-1:0];
        ptr_next = ptr_inc;
        if (sweep_end) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.valid) begin
          kind_r_next   = cmd.kind;
          cur_next      = cmd.block_index[ADDR_W-1:0];
          status_r_next = ST_OK;
          result_r_next = '0;
          count_next    = '0;
          state_next    = S_DONE;
          unique case (kind_t'(cmd.kind))
            KIND_FORMAT: begin
              ptr_next   = '0;
              state_next = S_FMT;
            end
            KIND_ALLOC, KIND_EXTEND: begin
              if (kind_t'(cmd.kind) == KIND_EXTEND && !in_table) begin
                state_next = S_DONE;
              end else if (32'(start) >= NUM_BLOCKS) begin
                status_r_next = ST_NOFREE;
              end else begin
                ptr_next   = PTR_W'(start);
                state_next = S_SRCH_RD;
              end
            end
            KIND_FREE, KIND_FIND: begin
              if (in_table) begin
                state_next = S_WALK_RD;
              end
            end
            KIND_NEXT: begin
              if (in_table) begin
                state_next = S_NEXT_RD;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_FMT: begin
        wr.en          = 1'b1;
        wr.addr        = ptr[ADDR_W-1:0];
        wr.data.used   = (32'(ptr) <= RSV_LAST);
        wr.data.nxt    = (32'(ptr) == RSV_LINK_SRC) ? IDX_W'(RSV_LINK_DST) : '0;
        ptr_next       = ptr_inc;
        if (sweep_end) begin
          state_next = S_DONE;
        end
      end
      S_SRCH_RD: begin
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (!rdata.used) begin
          result_r_next = IDX_W'(ptr);
          state_next    = (kind_r == KIND_EXTEND) ? S_LINK : S_CLAIM;
        end else if (sweep_end) begin
          status_r_next = ST_NOFREE;
          state_next    = S_DONE;
        end else begin
          ptr_next   = ptr_inc;
          state_next = S_SRCH_RD;
        end
      end
      S_LINK: begin
        wr.en        = 1'b1;
        wr.addr      = cur;
        wr.data.used = 1'b1;
        wr.data.nxt  = result_r;
        state_next   = S_CLAIM;
      end
      S_CLAIM: begin
        wr.en        = 1'b1;
        wr.addr      = ptr[ADDR_W-1:0];
        wr.data.used = 1'b1;
        state_next   = S_DONE;
      end
      S_WALK_RD: begin
        raddr      = cur;
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        count_next = count_inc;
        if (kind_r == KIND_FREE) begin
          wr.en   = 1'b1;
          wr.addr = cur;
        end
        if (rdata.nxt == '0 || 32'(rdata.nxt) >= NUM_BLOCKS) begin
          result_r_next = (kind_r == KIND_FIND) ? IDX_W'(cur) : '0;
          state_next    = S_DONE;
        end else if (32'(count_inc) >= NUM_BLOCKS) begin
          status_r_next = ST_OVERRUN;
          result_r_next = (kind_r == KIND_FIND) ? IDX_W'(cur) : '0;
          state_next    = S_DONE;
        end else begin
          cur_next   = rdata.nxt[ADDR_W-1:0];
          state_next = S_WALK_RD;
        end
      end
      S_NEXT_RD: begin
        raddr      = cur;
        state_next = S_NEXT_CHK;
      end
      S_NEXT_CHK: begin
        result_r_next = rdata.nxt;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ptr       <= ptr_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    kind_r   <= kind_r_next;
    count    <= count_next;
    status_r <= status_r_next;
    result_r <= result_r_next;
    if (out_load) begin
      out_status <= status_r;
      out_result <= result_r;
      out_count  <= count;
    end
  end

  `FCA_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> (state == S_CLEAR))
  `FCA_ASSERT(a_clear_zero, clk, rst, (state == S_CLEAR) |-> (wr.en && wr.data == '0))
  `FCA_ASSERT(a_load_done, clk, rst, $rose(out_valid) |-> $past(state == S_DONE))
  `FCA_ASSERT(a_count_bound, clk, rst, (state == S_WALK_CHK) |-> (32'(count) < NUM_BLOCKS))
  `FCA_ASSERT(a_search_bound, clk, rst, (state == S_SRCH_CHK) |-> (32'(ptr) < NUM_BLOCKS))

endmodule
`default_nettype wire

@@ sv/fat_chain_allocator.sv @@
// Clearing pass after rst writes one table entry a cycle; cmd not ready meanwhile.
// One command at a time; ready again from the edge that registers its result word.
// Format: sweep of the table. Next: reads the given entry and returns its link.
// Allocate/extend: search each block, then link (extend) and claim; free/find: walk the chain.
// Table memory has one read and one write port; searches and walks read each entry, then check it.
// Result word waits in an output register; rst clears control state and sets search start to 3.
`default_nettype none
module fat_chain_allocator import fca_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fca_cfg_if.sink   cfg,
  fca_cmd_if.sink   cmd,
  fca_rsp_if.source rsp
);

  logic [IDX_W-1:0]  search_start;
  tbl_wr_t           wr;
  logic [ADDR_W-1:0] raddr;
  entry_t            rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= CFG_RESET;
    end else if (cfg.valid) begin
      search_start <= cfg.first_search_index;
    end
  end

  fca_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rsp          (rsp),
    .search_start (search_start),
    .wr           (wr),
    .raddr        (raddr),
    .rdata        (rdata)
  );

  fca_table u_table (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
`default_nettype wire
